FILE: sv/rdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rdc_pkg;

    localparam int UNIT_FRAC_BITS = 16;
    localparam int COORD_W        = 32;
    localparam int UNIT_W         = 18;
    localparam int DIFF_W         = COORD_W + 1;
    localparam int COS_W          = 20;
    localparam int NUM_W          = 52;
    localparam int DIST_W         = 32;
    localparam int DIV_STEPS      = DIST_W;
    localparam int RAD_W          = 31;
    localparam int COS_OUT_W      = 17;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int LATENCY        = 41;

    localparam logic [COS_OUT_W-1:0] COS_MAX = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_CENTER_Z = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5,
        REG_RADIUS   = 3'd6
    } reg_index_t;

    // one word in flight through the divider
    typedef struct packed {
        logic                     valid;
        logic                     miss;
        logic [COS_W-1:0]         rem;
        logic [DIST_W-1:0]        low;
        logic [DIST_W-1:0]        quo;
        logic [COS_W-1:0]         cos_q;
        logic [DIST_W-1:0]        path;
        logic signed [UNIT_W-1:0] hx;
        logic signed [UNIT_W-1:0] hy;
        logic signed [UNIT_W-1:0] hz;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
    } rdc_div_t;

endpackage

`default_nettype wire

FILE: sv/rdc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] start_y,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] start_z,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  heading_x,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  heading_y,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  heading_z,
    input  wire logic [rdc_pkg::DIST_W-1:0]         path_length,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] center_x,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] center_y,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] center_z,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  normal_x,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  normal_y,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  normal_z,
    output rdc_pkg::rdc_div_t                      div_out
);
    import rdc_pkg::*;

    localparam int HN_W = 2 * UNIT_W;
    localparam int DN_W = DIFF_W + UNIT_W;
    localparam int CF_W = HN_W + 1;

    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic signed [DIFF_W-1:0] s1_d_reg [3];
    logic signed [UNIT_W-1:0] s1_h_reg [3];
    logic [DIST_W-1:0]        s1_path_reg;

    logic signed [DIFF_W-1:0] s2_d_reg [3];
    logic signed [UNIT_W-1:0] s2_h_reg [3];
    logic [DIST_W-1:0]        s2_path_reg;
    logic signed [HN_W-1:0]   s2_hn_reg [3];
    logic signed [DN_W-1:0]   s2_dn_reg [3];

    logic signed [DIFF_W-1:0] s3_d_reg [3];
    logic signed [UNIT_W-1:0] s3_h_reg [3];
    logic [DIST_W-1:0]        s3_path_reg;
    logic [COS_W-1:0]         s3_cos_reg;
    logic [NUM_W-1:0]         s3_num_reg;
    logic                     s3_miss_reg;

    logic [CF_W-1:0]          cos_full;
    logic [NUM_W-1:0]         num;
    logic [COS_W-1:0]         num_hi;
    rdc_div_t                 div_reg;
    rdc_div_t                 div_next;

    always_comb
    begin
        cos_full = {s2_hn_reg[0][HN_W-1], s2_hn_reg[0]}
                 + {s2_hn_reg[1][HN_W-1], s2_hn_reg[1]}
                 + {s2_hn_reg[2][HN_W-1], s2_hn_reg[2]};
        num = {s2_dn_reg[0][DN_W-1], s2_dn_reg[0]}
            + {s2_dn_reg[1][DN_W-1], s2_dn_reg[1]}
            + {s2_dn_reg[2][DN_W-1], s2_dn_reg[2]};
    end

    always_comb
    begin
        // t must fit in the quotient width, else it is past any path
        num_hi = s3_num_reg[NUM_W-1-:COS_W];
        div_next.valid = s3_valid_reg;
        div_next.miss  = s3_miss_reg | (num_hi >= s3_cos_reg);
        div_next.rem   = num_hi;
        div_next.low   = s3_num_reg[DIST_W-1:0];
        div_next.quo   = '0;
        div_next.cos_q = s3_cos_reg;
        div_next.path  = s3_path_reg;
        div_next.hx    = s3_h_reg[0];
        div_next.hy    = s3_h_reg[1];
        div_next.hz    = s3_h_reg[2];
        div_next.dx    = s3_d_reg[0];
        div_next.dy    = s3_d_reg[1];
        div_next.dz    = s3_d_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            div_reg.valid <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            div_reg      <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_d_reg[0] <= {center_x[COORD_W-1], center_x} - {start_x[COORD_W-1], start_x};
        s1_d_reg[1] <= {center_y[COORD_W-1], center_y} - {start_y[COORD_W-1], start_y};
        s1_d_reg[2] <= {center_z[COORD_W-1], center_z} - {start_z[COORD_W-1], start_z};
        s1_h_reg[0] <= heading_x;
        s1_h_reg[1] <= heading_y;
        s1_h_reg[2] <= heading_z;
        s1_path_reg <= path_length;

        s2_hn_reg[0] <= s1_h_reg[0] * normal_x;
        s2_hn_reg[1] <= s1_h_reg[1] * normal_y;
        s2_hn_reg[2] <= s1_h_reg[2] * normal_z;
        s2_dn_reg[0] <= s1_d_reg[0] * normal_x;
        s2_dn_reg[1] <= s1_d_reg[1] * normal_y;
        s2_dn_reg[2] <= s1_d_reg[2] * normal_z;
        s2_d_reg     <= s1_d_reg;
        s2_h_reg     <= s1_h_reg;
        s2_path_reg  <= s1_path_reg;

        // cosine under one lsb, or plane behind the start, is a miss
        s3_miss_reg <= cos_full[CF_W-1] | (cos_full[CF_W-2 -: COS_W] == '0)
                     | num[NUM_W-1];
        s3_cos_reg  <= cos_full[CF_W-2 -: COS_W];
        s3_num_reg  <= num;
        s3_d_reg    <= s2_d_reg;
        s3_h_reg    <= s2_h_reg;
        s3_path_reg <= s2_path_reg;
    end

    assign div_out = div_reg;

endmodule

`default_nettype wire

FILE: sv/rdc_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_div (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  rdc_pkg::rdc_div_t div_in,
    output rdc_pkg::rdc_div_t div_out
);
    import rdc_pkg::*;

    rdc_div_t stage_src  [DIV_STEPS];
    rdc_div_t stage_next [DIV_STEPS];
    rdc_div_t stage_reg  [DIV_STEPS];

    assign stage_src[0] = div_in;

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [COS_W:0] trial;
        logic           ge;

        if (k > 0)
        begin : g_link
            assign stage_src[k] = stage_reg[k-1];
        end

        // one restoring quotient bit per stage
        always_comb
        begin
            trial = {stage_src[k].rem, stage_src[k].low[DIST_W-1]};
            ge    = trial >= {1'b0, stage_src[k].cos_q};
            stage_next[k]     = stage_src[k];
            stage_next[k].rem = ge ? COS_W'(trial - {1'b0, stage_src[k].cos_q})
                                   : trial[COS_W-1:0];
            stage_next[k].low = {stage_src[k].low[DIST_W-2:0], 1'b0};
            stage_next[k].quo = {stage_src[k].quo[DIST_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stage_reg[k].valid <= 1'b0;
            end
            else
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign div_out = stage_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

FILE: sv/rdc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  rdc_pkg::rdc_div_t                   div_in,
    input  wire logic [rdc_pkg::RAD_W-1:0]      disc_radius,
    output logic                                done,
    output logic                                crosses,
    output logic [rdc_pkg::COS_OUT_W-1:0]       entry_cosine,
    output logic [rdc_pkg::DIST_W-1:0]          crossing_distance
);
    import rdc_pkg::*;

    localparam int TH_W  = DIST_W + 1 + UNIT_W;
    localparam int E_W   = TH_W + 1;
    localparam int SQ_W  = 2 * RAD_W;
    localparam int SUM_W = SQ_W + 2;

    logic                     a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic                     a_miss_reg, b_miss_reg, c_miss_reg, d_miss_reg;
    logic [COS_W-1:0]         a_cos_reg, b_cos_reg, c_cos_reg, d_cos_reg;
    logic [DIST_W-1:0]        a_t_reg, b_t_reg, c_t_reg, d_t_reg;
    logic signed [TH_W-1:0]   a_th_reg [3];
    logic signed [DIFF_W-1:0] a_d_reg [3];
    logic [RAD_W-1:0]         b_m_reg [3];
    logic [SQ_W-1:0]          c_sq_reg [3];
    logic [SUM_W-1:0]         d_sum_reg;
    logic [SQ_W-1:0]          rad_sq_reg;

    logic                     done_reg, crosses_reg;
    logic [COS_OUT_W-1:0]     cos_out_reg;
    logic [DIST_W-1:0]        dist_out_reg;

    logic [E_W-1:0]           e_val [3];
    logic [E_W-1:0]           e_abs [3];
    logic                     e_big;
    logic                     hit;
    logic [COS_OUT_W-1:0]     cos_sat;

    always_comb
    begin
        e_big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            e_val[i] = {a_th_reg[i][TH_W-1], a_th_reg[i]}
                     - {{(E_W-DIFF_W-UNIT_FRAC_BITS){a_d_reg[i][DIFF_W-1]}},
                        a_d_reg[i], {UNIT_FRAC_BITS{1'b0}}};
            e_abs[i] = e_val[i][E_W-1] ? E_W'(~e_val[i] + 1'b1) : e_val[i];
            // any magnitude of 2^31 or more lies outside every disc
            e_big = e_big | (e_abs[i][E_W-1 : UNIT_FRAC_BITS+RAD_W] != '0);
        end
    end

    always_comb
    begin
        hit     = d_valid_reg & ~d_miss_reg & (d_sum_reg <= {2'b0, rad_sq_reg});
        cos_sat = ({1'b0, d_cos_reg} > {{(COS_W+1-COS_OUT_W){1'b0}}, COS_MAX})
                ? COS_MAX : COS_OUT_W'(d_cos_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= div_in.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            done_reg    <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_miss_reg  <= div_in.miss | (div_in.quo > div_in.path);
        a_cos_reg   <= div_in.cos_q;
        a_t_reg     <= div_in.quo;
        a_th_reg[0] <= $signed({1'b0, div_in.quo}) * div_in.hx;
        a_th_reg[1] <= $signed({1'b0, div_in.quo}) * div_in.hy;
        a_th_reg[2] <= $signed({1'b0, div_in.quo}) * div_in.hz;
        a_d_reg[0]  <= div_in.dx;
        a_d_reg[1]  <= div_in.dy;
        a_d_reg[2]  <= div_in.dz;

        b_miss_reg <= a_miss_reg | e_big;
        b_cos_reg  <= a_cos_reg;
        b_t_reg    <= a_t_reg;
        for (int i = 0; i < 3; i++)
        begin
            b_m_reg[i] <= e_abs[i][UNIT_FRAC_BITS +: RAD_W];
        end

        c_miss_reg <= b_miss_reg;
        c_cos_reg  <= b_cos_reg;
        c_t_reg    <= b_t_reg;
        for (int i = 0; i < 3; i++)
        begin
            c_sq_reg[i] <= b_m_reg[i] * b_m_reg[i];
        end
        rad_sq_reg <= disc_radius * disc_radius;

        d_miss_reg <= c_miss_reg;
        d_cos_reg  <= c_cos_reg;
        d_t_reg    <= c_t_reg;
        d_sum_reg  <= {2'b0, c_sq_reg[0]} + {2'b0, c_sq_reg[1]} + {2'b0, c_sq_reg[2]};

        crosses_reg  <= hit;
        cos_out_reg  <= hit ? cos_sat : '0;
        dist_out_reg <= hit ? d_t_reg : '0;
    end

    assign done              = done_reg;
    assign crosses           = crosses_reg;
    assign entry_cosine      = cos_out_reg;
    assign crossing_distance = dist_out_reg;

endmodule

`default_nettype wire

FILE: sv/ray_disc_crossing_test.sv
// Ray / disc crossing test for photon transport steps.
// Input: pulse start with the step fields (start position, unit heading,
// path length); the step is taken at a rising edge where start is high and
// busy is low. Steps may be issued on every cycle.
// Output: done is high for one cycle with crosses, entry_cosine and
// crossing_distance for that step; one result per step, in issue order.
// A taken step passes four dot product stages, then the divider for the
// distance along the ray, one quotient bit per stage over 32 stages,
// then five stages for the crossing point check.
// Throughput is one step per cycle while busy is low.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; the
// disc center, normal and radius are to be written by the user only while
// no step is in flight; the block itself does not enforce this.
// Indexes past the radius are ignored. cfg_ready is always high.
// Reset clears the pipeline and loads the reset disc (unit radius at the
// origin, normal along z); busy is high for the first cycle after reset.
// The receiver cannot hold results off, so nothing inside ever stalls.
`timescale 1ns / 1ps
`default_nettype none

module ray_disc_crossing_test (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] start_x,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] start_y,
    input  wire logic signed [rdc_pkg::COORD_W-1:0] start_z,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  heading_x,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  heading_y,
    input  wire logic signed [rdc_pkg::UNIT_W-1:0]  heading_z,
    input  wire logic [rdc_pkg::DIST_W-1:0]         path_length,
    output logic                                    done,
    output logic                                    crosses,
    output logic [rdc_pkg::COS_OUT_W-1:0]           entry_cosine,
    output logic [rdc_pkg::DIST_W-1:0]              crossing_distance,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [rdc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [rdc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rdc_pkg::*;

    logic signed [COORD_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic signed [UNIT_W-1:0]  normal_x_reg, normal_y_reg, normal_z_reg;
    logic [RAD_W-1:0]          radius_reg;
    logic                      busy_reg;
    rdc_div_t                  front_word;
    rdc_div_t                  div_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            normal_x_reg <= '0;
            normal_y_reg <= '0;
            normal_z_reg <= UNIT_W'(1 << UNIT_FRAC_BITS);
            radius_reg   <= RAD_W'(1 << UNIT_FRAC_BITS);
            busy_reg     <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CENTER_X: center_x_reg <= cfg_data;
                    REG_CENTER_Y: center_y_reg <= cfg_data;
                    REG_CENTER_Z: center_z_reg <= cfg_data;
                    REG_NORMAL_X: normal_x_reg <= cfg_data[UNIT_W-1:0];
                    REG_NORMAL_Y: normal_y_reg <= cfg_data[UNIT_W-1:0];
                    REG_NORMAL_Z: normal_z_reg <= cfg_data[UNIT_W-1:0];
                    REG_RADIUS:   radius_reg   <= cfg_data[RAD_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign busy      = busy_reg;

    rdc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (start & ~busy_reg),
        .start_x     (start_x),
        .start_y     (start_y),
        .start_z     (start_z),
        .heading_x   (heading_x),
        .heading_y   (heading_y),
        .heading_z   (heading_z),
        .path_length (path_length),
        .center_x    (center_x_reg),
        .center_y    (center_y_reg),
        .center_z    (center_z_reg),
        .normal_x    (normal_x_reg),
        .normal_y    (normal_y_reg),
        .normal_z    (normal_z_reg),
        .div_out     (front_word)
    );

    rdc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_in  (front_word),
        .div_out (div_word)
    );

    rdc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .div_in            (div_word),
        .disc_radius       (radius_reg),
        .done              (done),
        .crosses           (crosses),
        .entry_cosine      (entry_cosine),
        .crossing_distance (crossing_distance)
    );

endmodule

`default_nettype wire

FILE: sv/rdc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rdc_checker (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                done,
    input wire logic                                crosses,
    input wire logic [rdc_pkg::COS_OUT_W-1:0]       entry_cosine,
    input wire logic [rdc_pkg::DIST_W-1:0]          crossing_distance
);
    import rdc_pkg::*;

    // every accepted step gives a result word
    a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted step gave no result");

    a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##LATENCY !done)
        else $error("result word with no step behind it");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !crosses) |-> (entry_cosine == '0 && crossing_distance == '0))
        else $error("miss word carries nonzero fields");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && crosses) |-> (entry_cosine != '0 && entry_cosine <= COS_MAX))
        else $error("crossing cosine out of range");

endmodule

bind ray_disc_crossing_test rdc_checker u_rdc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .done              (done),
    .crosses           (crosses),
    .entry_cosine      (entry_cosine),
    .crossing_distance (crossing_distance)
);

`default_nettype wire

FILE: sim/tb_ray_disc_crossing_test.sv
`timescale 1ns / 1ps

module tb_ray_disc_crossing_test;
    import rdc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        logic signed [UNIT_W-1:0]  hx;
        logic signed [UNIT_W-1:0]  hy;
        logic signed [UNIT_W-1:0]  hz;
        logic [DIST_W-1:0]         path;
    } photon_step_t;

    typedef struct packed {
        logic                 hit;
        logic [COS_OUT_W-1:0] cosine;
        logic [DIST_W-1:0]    distance;
    } crossing_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [COORD_W-1:0] start_x, start_y, start_z;
    logic signed [UNIT_W-1:0]  heading_x, heading_y, heading_z;
    logic [DIST_W-1:0]         path_length;
    logic done;
    logic crosses;
    logic [COS_OUT_W-1:0] entry_cosine;
    logic [DIST_W-1:0]    crossing_distance;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // disc as the block should hold it
    logic signed [COORD_W-1:0] disc_ctr [3];
    logic signed [UNIT_W-1:0]  disc_nrm [3];
    logic [RAD_W-1:0]          disc_rad;

    photon_step_t pending_steps[$];
    crossing_t    expected_crossings[$];
    photon_step_t cur_step;
    logic took;
    int   gap_left;
    bit   idle_on;
    int   mismatches;
    int   steps_sent;
    int   hits_seen;
    int   results_seen;
    bit   failed;

    ray_disc_crossing_test uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .start_x(start_x), .start_y(start_y), .start_z(start_z),
        .heading_x(heading_x), .heading_y(heading_y), .heading_z(heading_z),
        .path_length(path_length), .done(done), .crosses(crosses),
        .entry_cosine(entry_cosine), .crossing_distance(crossing_distance),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic crossing_t disc_crossing(input photon_step_t s);
        crossing_t r;
        longint d [3];
        longint h [3];
        longint n [3];
        longint cos_full;
        longint num;
        longint cos_q;
        longint t;
        longint e;
        longint unsigned m;
        longint unsigned sum;
        longint unsigned rad;
        r = '0;
        d[0] = longint'(disc_ctr[0]) - longint'(s.px);
        d[1] = longint'(disc_ctr[1]) - longint'(s.py);
        d[2] = longint'(disc_ctr[2]) - longint'(s.pz);
        h[0] = longint'(s.hx);
        h[1] = longint'(s.hy);
        h[2] = longint'(s.hz);
        cos_full = 0;
        num = 0;
        sum = 0;
        rad = longint'({33'd0, disc_rad});
        for (int i = 0; i < 3; i++)
        begin
            n[i] = longint'(disc_nrm[i]);
            cos_full += h[i] * n[i];
            num += d[i] * n[i];
        end
        if (cos_full <= 0)
            return r;
        cos_q = cos_full >>> UNIT_FRAC_BITS;
        if (cos_q == 0 || num < 0)
            return r;
        t = num / cos_q;
        if (t > longint'({32'd0, s.path}))
            return r;
        for (int i = 0; i < 3; i++)
        begin
            e = t * h[i] - d[i] * 65536;
            m = (e < 0) ? longint'(-e) : longint'(e);
            m = m >> UNIT_FRAC_BITS;
            if (m >= 64'h8000_0000)
                return r;
            sum += m * m;
        end
        if (sum > rad * rad)
            return r;
        r.hit      = 1'b1;
        r.cosine   = (cos_q > 65536) ? COS_MAX : COS_OUT_W'(cos_q);
        r.distance = t[31:0];
        return r;
    endfunction

    // step aimed at the disc: back off from a point near the center
    function automatic photon_step_t aimed_step();
        photon_step_t s;
        longint t;
        longint spread;
        longint h [3];
        longint p [3];
        t = longint'($urandom_range(0, 32'h0010_0000));
        spread = (disc_rad > 31'h0004_0000) ? 64'h0004_0000 : longint'(disc_rad) + 2;
        for (int i = 0; i < 3; i++)
        begin
            h[i] = longint'(disc_nrm[i]);
            if ($urandom_range(0, 2) == 0)
                h[i] += longint'($urandom_range(0, 16384)) - 8192;
            p[i] = longint'(disc_ctr[i]) - ((t * h[i]) >>> 16)
                   + longint'($urandom_range(0, 2 * spread)) - spread;
        end
        s.px = p[0][31:0];
        s.py = p[1][31:0];
        s.pz = p[2][31:0];
        s.hx = h[0][17:0];
        s.hy = h[1][17:0];
        s.hz = h[2][17:0];
        case ($urandom_range(0, 7))
            0: s.path = (t > 0) ? DIST_W'(t - 1) : '0;
            1: s.path = DIST_W'(t);
            2: s.path = $urandom;
            default: s.path = DIST_W'(t + longint'($urandom_range(0, 32'h0002_0000)));
        endcase
        return s;
    endfunction

    function automatic photon_step_t random_step();
        photon_step_t s;
        s.px = $urandom;
        s.py = $urandom;
        s.pz = $urandom;
        s.hx = $urandom;
        s.hy = $urandom;
        s.hz = $urandom;
        s.path = $urandom;
        if ($urandom_range(0, 1) == 0)
        begin
            // near the disc, with unit-scale headings
            s.px = disc_ctr[0] + $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh4_0000;
            s.py = disc_ctr[1] + $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh4_0000;
            s.pz = disc_ctr[2] + $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh4_0000;
            s.hx = 18'($urandom_range(0, 131072)) - 18'sd65536;
            s.hy = 18'($urandom_range(0, 131072)) - 18'sd65536;
            s.hz = 18'($urandom_range(0, 131072)) - 18'sd65536;
            s.path = $urandom_range(0, 32'h0010_0000);
        end
        return s;
    endfunction

    function automatic photon_step_t make_step(input logic signed [31:0] x, y, z,
                                               input logic signed [17:0] a, b, c,
                                               input logic [31:0] len);
        photon_step_t s;
        s.px = x; s.py = y; s.pz = z;
        s.hx = a; s.hy = b; s.hz = c;
        s.path = len;
        return s;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_CENTER_X: disc_ctr[0] = val;
            REG_CENTER_Y: disc_ctr[1] = val;
            REG_CENTER_Z: disc_ctr[2] = val;
            REG_NORMAL_X: disc_nrm[0] = val[17:0];
            REG_NORMAL_Y: disc_nrm[1] = val[17:0];
            REG_NORMAL_Z: disc_nrm[2] = val[17:0];
            REG_RADIUS:   disc_rad    = val[30:0];
            default: ;
        endcase
    endtask

    task automatic load_disc(input logic [31:0] cx, cy, cz, nx, ny, nz, r);
        // junk in the unused high bits must be dropped
        write_reg(REG_NORMAL_X, {$urandom} << 18 | (nx & 32'h3ffff));
        write_reg(REG_NORMAL_Y, ny);
        write_reg(REG_NORMAL_Z, nz);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_UNUSED, $urandom);
        write_reg(REG_RADIUS, r);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_steps.size() != 0 || start || expected_crossings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            pending_steps.push_back(($urandom_range(0, 9) < 6) ? aimed_step() : random_step());
        drain();
    endtask

    // driver
    always @(negedge clk)
    begin
        if (rst_n && (!start || took))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end
            else if (pending_steps.size() != 0)
            begin
                cur_step = pending_steps.pop_front();
                start_x <= cur_step.px;
                start_y <= cur_step.py;
                start_z <= cur_step.pz;
                heading_x <= cur_step.hx;
                heading_y <= cur_step.hy;
                heading_z <= cur_step.hz;
                path_length <= cur_step.path;
                start <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    gap_left <= $urandom_range(1, 3);
            end
            else
                start <= 1'b0;
        end
    end

    // accept side and result checker
    always @(posedge clk)
    begin
        crossing_t want;
        took <= start && !busy && rst_n;
        if (rst_n && start && !busy)
        begin
            expected_crossings.push_back(disc_crossing(cur_step));
            steps_sent++;
        end
        if (rst_n && done)
        begin
            results_seen++;
            if (crosses)
                hits_seen++;
            if (expected_crossings.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: crosses=%0b cos=%0d dist=%0d",
                             crosses, entry_cosine, crossing_distance);
            end
            else
            begin
                want = expected_crossings.pop_front();
                if (crosses !== want.hit || entry_cosine !== want.cosine ||
                    crossing_distance !== want.distance)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: crosses %0b/%0b cos %0d/%0d dist %0d/%0d (exp/got)",
                                 want.hit, crosses, want.cosine, entry_cosine,
                                 want.distance, crossing_distance);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        start = 1'b0;
        start_x = '0; start_y = '0; start_z = '0;
        heading_x = '0; heading_y = '0; heading_z = '0;
        path_length = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        took = 1'b0;
        gap_left = 0;
        idle_on = 1'b1;
        mismatches = 0;
        steps_sent = 0;
        hits_seen = 0;
        results_seen = 0;
        failed = 1'b0;
        disc_ctr[0] = '0; disc_ctr[1] = '0; disc_ctr[2] = '0;
        disc_nrm[0] = '0; disc_nrm[1] = '0; disc_nrm[2] = 18'sd65536;
        disc_rad = 31'd65536;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset disc: unit radius at the origin facing +z
        pending_steps.push_back(make_step(0, 0, -65536, 0, 0, 65536, 65536));
        pending_steps.push_back(make_step(65536, 0, -65536, 0, 0, 65536, 65536));
        pending_steps.push_back(make_step(65537, 0, -65536, 0, 0, 65536, 65536));
        pending_steps.push_back(make_step(0, 0, -65536, 0, 0, 65536, 65535));
        pending_steps.push_back(make_step(0, 0, 0, 0, 0, 65536, 0));
        pending_steps.push_back(make_step(0, 0, 65536, 0, 0, 65536, 32'hffff_ffff));
        pending_steps.push_back(make_step(0, 0, -65536, 65536, 0, 0, 32'hffff_ffff));
        pending_steps.push_back(make_step(0, 0, -65536, 0, 0, -65536, 32'hffff_ffff));
        pending_steps.push_back(make_step(0, 0, -65536, 0, 0, 18'sh1ffff, 32'hffff_ffff));
        pending_steps.push_back(make_step(0, 0, -65536, 0, 0, 18'sh20000, 32'hffff_ffff));
        pending_steps.push_back(make_step(0, 0, -65536, 0, 0, 1, 32'hffff_ffff));
        pending_steps.push_back(make_step(0, 0, -65536, 46341, 0, 46341, 32'hffff_ffff));
        pending_steps.push_back(make_step(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
                                          18'sh1ffff, 18'sh1ffff, 18'sh1ffff, 32'hffff_ffff));
        pending_steps.push_back(make_step(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                          18'sh20000, 18'sh20000, 65536, 32'hffff_ffff));
        pending_steps.push_back(make_step(-1, -1, -1, -1, -1, -1, 0));
        pending_steps.push_back(make_step(0, 0, 32'sh8000_0000, 0, 0, 65536, 32'hffff_ffff));
        pending_steps.push_back(make_step(0, 0, -3, 0, 0, 65536, 3));
        drain();
        run_random(150);

        load_disc(32'h0001_8000, 32'hfffe_0000, 32'h0003_0000, 65536, 0, 0, 32'h0002_0000);
        pending_steps.push_back(make_step(0, -131072, 196608, 65536, 0, 0, 98304));
        run_random(230);
        load_disc(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'h3_0000, 32'h7fff_ffff);
        run_random(200);
        load_disc(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 37837, 37837, 37837, 0);
        run_random(200);
        load_disc(0, 0, 0, 32'h2_0000, 32'h1_ffff, 0, 32'h0010_0000);
        run_random(200);
        for (int k = 0; k < 4; k++)
        begin
            load_disc($urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                      $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                      $urandom_range(0, 32'h0100_0000) - 32'h0080_0000,
                      $urandom_range(0, 75000) - 37500, $urandom_range(0, 75000) - 37500,
                      $urandom_range(0, 75000) - 37500, $urandom_range(1, 32'h0008_0000));
            if (k == 3)
                idle_on = 1'b0;
            run_random(200);
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (expected_crossings.size() != 0)
        begin
            failed = 1'b1;
            $display("%0d results never arrived", expected_crossings.size());
        end
        $display("steps sent %0d, results %0d, crossings %0d, over 9 disc settings",
                 steps_sent, results_seen, hits_seen);
        $display("mismatches %0d", mismatches);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
sv/rdc_pkg.sv
sv/rdc_front.sv
sv/rdc_div.sv
sv/rdc_back.sv
sv/ray_disc_crossing_test.sv
sv/rdc_checker.sv
sim/tb_ray_disc_crossing_test.sv
